>>> hw/rtl/ced_pkg.sv
package ced_pkg;

  // Most bytes that a single input character can produce
  localparam int unsigned MaxResults = 3;

  // Default depth of the queue between front and back
  localparam int unsigned QueueDepth = 2;

  // One queue entry: every result byte caused by one input character
  typedef struct packed {
    logic [MaxResults-1:0][7:0] bytes;  // results in order, slot 0 first
    logic [1:0]                 n;      // number of results, 1..3
    logic                       empty;  // single result with no character
    logic                       last;   // caused by the string's last character
  } bundle_t;

endpackage

>>> hw/rtl/ced_front.sv
module ced_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic [7:0]       in_byte_i,
  input  logic             string_last_i,
  output logic             push_o,
  output ced_pkg::bundle_t bundle_o
);

  typedef enum logic [1:0] {
    MODE_PLAIN,
    MODE_ESC,
    MODE_OCT,
    MODE_HEX
  } mode_e;

  localparam logic [7:0] CharBackslash = 8'h5c;
  localparam logic [7:0] CharZero      = 8'h30;
  localparam logic [7:0] CharX         = 8'h78;

  // Append one byte to the result list
  function automatic ced_pkg::bundle_t push_byte(ced_pkg::bundle_t r, logic [7:0] c);
    if (r.n != 2'd3) begin
      r.bytes[r.n] = c;
      r.n          = r.n + 2'd1;
    end
    return r;
  endfunction

  function automatic logic is_oct(logic [7:0] c);
    return c[7:3] == 5'b00110;
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39)      v = c - 8'h30;
    else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h57;
    else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h37;
    return v[3:0];
  endfunction

  // Letter escapes: {hit, control code}
  function automatic logic [8:0] esc_code(logic [7:0] c);
    logic [8:0] r;
    unique case (c)
      8'h61:   r = {1'b1, 8'h07};  // a
      8'h62:   r = {1'b1, 8'h08};  // b
      8'h66:   r = {1'b1, 8'h0c};  // f
      8'h6e:   r = {1'b1, 8'h0a};  // n
      8'h72:   r = {1'b1, 8'h0d};  // r
      8'h74:   r = {1'b1, 8'h09};  // t
      8'h76:   r = {1'b1, 8'h0b};  // v
      default: r = {1'b0, 8'h00};
    endcase
    return r;
  endfunction

  mode_e            mode_q, mode_d;
  logic [7:0]       hi_q, hi_d;
  logic [7:0]       lo_q, lo_d;
  logic [1:0]       cnt_q, cnt_d;
  ced_pkg::bundle_t res;
  logic [8:0]       esc;
  logic             fire;

  assign esc  = esc_code(in_byte_i);
  assign fire = in_valid_i && in_ready_i;

  // Classify the character against the scan state and build its results
  always_comb begin
    res    = '0;
    mode_d = mode_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    cnt_d  = cnt_q;
    unique case (mode_q)
      MODE_ESC: begin
        mode_d = MODE_PLAIN;
        hi_d   = '0;
        lo_d   = '0;
        cnt_d  = '0;
        if (esc[8]) begin
          res = push_byte(res, esc[7:0]);
        end else if (in_byte_i == CharX) begin
          mode_d = MODE_HEX;
        end else if (is_oct(in_byte_i)) begin
          mode_d = MODE_OCT;
          lo_d   = in_byte_i;
          cnt_d  = 2'd1;
        end else begin
          res = push_byte(res, in_byte_i);
        end
      end
      MODE_OCT: begin
        if (is_oct(in_byte_i) && cnt_q < 2'd2) begin
          hi_d  = lo_q;
          lo_d  = in_byte_i;
          cnt_d = 2'd2;
        end else begin
          if (is_oct(in_byte_i)) begin
            // third digit: low 8 bits of the octal value
            res = push_byte(res, {hi_q[1:0], lo_q[2:0], in_byte_i[2:0]});
          end else begin
            // short run as text, lone zero as NUL; then char as plain text
            if (cnt_q == 2'd1) begin
              res = push_byte(res, (lo_q == CharZero) ? 8'h00 : lo_q);
            end else begin
              res = push_byte(res, hi_q);
              res = push_byte(res, lo_q);
            end
          end
          mode_d = MODE_PLAIN;
          hi_d   = '0;
          lo_d   = '0;
          cnt_d  = '0;
          if (!is_oct(in_byte_i)) begin
            if (in_byte_i == CharBackslash) mode_d = MODE_ESC;
            else res = push_byte(res, in_byte_i);
          end
        end
      end
      MODE_HEX: begin
        if (is_hex(in_byte_i) && cnt_q == 2'd0) begin
          lo_d  = in_byte_i;
          cnt_d = 2'd1;
        end else begin
          if (is_hex(in_byte_i)) begin
            res = push_byte(res, {hex_val(lo_q), hex_val(in_byte_i)});
          end else begin
            res = push_byte(res, CharX);
            if (cnt_q != 2'd0) res = push_byte(res, lo_q);
          end
          mode_d = MODE_PLAIN;
          hi_d   = '0;
          lo_d   = '0;
          cnt_d  = '0;
          if (!is_hex(in_byte_i)) begin
            if (in_byte_i == CharBackslash) mode_d = MODE_ESC;
            else res = push_byte(res, in_byte_i);
          end
        end
      end
      default: begin
        if (in_byte_i == CharBackslash) mode_d = MODE_ESC;
        else res = push_byte(res, in_byte_i);
      end
    endcase

    // End of string: flush runs, drop a trailing backslash, mark empty
    if (string_last_i) begin
      if (mode_d == MODE_OCT) begin
        if (cnt_d == 2'd1) begin
          res = push_byte(res, (lo_d == CharZero) ? 8'h00 : lo_d);
        end else begin
          res = push_byte(res, hi_d);
          res = push_byte(res, lo_d);
        end
      end else if (mode_d == MODE_HEX) begin
        res = push_byte(res, CharX);
        if (cnt_d != 2'd0) res = push_byte(res, lo_d);
      end
      mode_d = MODE_PLAIN;
      hi_d   = '0;
      lo_d   = '0;
      cnt_d  = '0;
      if (res.n == 2'd0) begin
        res.n     = 2'd1;
        res.empty = 1'b1;
      end
    end
    res.last = string_last_i;
  end

  assign bundle_o = res;
  assign push_o   = fire && (res.n != 2'd0);

  // Scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_PLAIN;
      hi_q   <= '0;
      lo_q   <= '0;
      cnt_q  <= '0;
    end else if (fire) begin
      mode_q <= mode_d;
      hi_q   <= hi_d;
      lo_q   <= lo_d;
      cnt_q  <= cnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && string_last_i) |-> push_o)
    else $error("last character of a string produced no transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && bundle_o.empty) |-> (bundle_o.n == 2'd1))
    else $error("empty end marker carries extra results");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && string_last_i) |=> (mode_q == MODE_PLAIN && cnt_q == 2'd0))
    else $error("scan state not cleared after end of string");

endmodule

>>> hw/rtl/ced_fifo.sv
module ced_fifo #(
  parameter int unsigned Depth = ced_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ced_pkg::bundle_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output ced_pkg::bundle_t data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  ced_pkg::bundle_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      if (do_push && !do_pop)      cnt_q <= cnt_q + CntW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CntW'(1);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue fill count overflow");

endmodule

>>> hw/rtl/ced_back.sv
module ced_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ced_pkg::bundle_t head_i,
  input  logic             head_valid_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             byte_valid_o,
  output logic             run_last_o,
  output logic             string_end_o
);

  logic [1:0] idx_q;
  logic       xfer;

  // Walk the head entry one result per transfer
  assign out_valid_o  = head_valid_i;
  assign out_byte_o   = head_i.bytes[idx_q];
  assign byte_valid_o = !head_i.empty;
  assign run_last_o   = (idx_q == head_i.n - 2'd1);
  assign string_end_o = head_i.last;
  assign xfer         = out_valid_o && out_ready_i;
  assign pop_o        = xfer && run_last_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (xfer) begin
      idx_q <= run_last_o ? 2'd0 : idx_q + 2'd1;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (idx_q < head_i.n))
    else $error("result index beyond head entry");

endmodule

>>> hw/rtl/c_escape_sequence_decoder_core.sv
// Each character's results are registered in the queue and offered from its head.
// Throughput: one character per cycle while each gives at most one result and the
//   output is ready; each of a character's results (up to 3) takes a transfer.
// A queue (two entries by default) between classifier and output absorbs stalls.
// Reset (rst_ni low, asynchronous) returns to plain text and empties the queue.
module c_escape_sequence_decoder_core #(
  parameter int unsigned QueueDepth = ced_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       string_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       run_last_o,
  output logic       string_end_o
);

  ced_pkg::bundle_t push_data, head;
  logic             push, full, empty, pop;

  assign in_ready_o = !full;

  ced_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .in_byte_i     (in_byte_i),
    .string_last_i (string_last_i),
    .push_o        (push),
    .bundle_o      (push_data)
  );

  ced_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (head),
    .empty_o (empty)
  );

  ced_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (!empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .run_last_o   (run_last_o),
    .string_end_o (string_end_o)
  );

endmodule

>>> tb/c_escape_sequence_decoder_core_tb.sv
module c_escape_sequence_decoder_core_tb;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned PhaseChars  = 48;
  localparam int unsigned ReportLimit = 10;

  // Decoder scan state
  typedef enum logic [2:0] {
    SCAN_PLAIN,
    SCAN_ESC,
    SCAN_OCT,
    SCAN_HEX
  } scan_mode_e;

  // One decoded output character as seen on the result port
  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       run_end;
    logic       str_end;
  } decoded_t;

  // Unescape predictor plus in-order checker of decoded characters
  class unescape_checker;
    scan_mode_e  mode;
    logic [15:0] held;
    logic [1:0]  held_n;
    logic [7:0]  step_chars[$];
    logic        step_has[$];
    decoded_t    expected_chars[$];
    int unsigned mismatches;

    function new();
      go_plain();
      mismatches = 0;
    endfunction

    function void go_plain();
      mode   = SCAN_PLAIN;
      held   = '0;
      held_n = '0;
    endfunction

    function void emit(logic [7:0] c, logic has);
      if (step_chars.size() < ced_pkg::MaxResults) begin
        step_chars.push_back(c);
        step_has.push_back(has);
      end
    endfunction

    function bit is_oct(logic [7:0] c);
      return (c >= "0") && (c <= "7");
    endfunction

    function bit is_hex(logic [7:0] c);
      return ((c >= "0") && (c <= "9")) || ((c >= "a") && (c <= "f")) ||
             ((c >= "A") && (c <= "F"));
    endfunction

    function logic [3:0] hex_val(logic [7:0] c);
      logic [7:0] v;
      v = 8'd0;
      if ((c >= "0") && (c <= "9")) v = c - "0";
      else if ((c >= "a") && (c <= "f")) v = c - "a" + 8'd10;
      else if ((c >= "A") && (c <= "F")) v = c - "A" + 8'd10;
      return v[3:0];
    endfunction

    function void plain_char(logic [7:0] c);
      if (c == "\\") mode = SCAN_ESC;
      else emit(c, 1'b1);
    endfunction

    // Incomplete octal run: a lone zero is NUL, otherwise digits go out as text
    function void flush_oct();
      if (held_n == 2'd1) begin
        emit((held[7:0] == "0") ? 8'h00 : held[7:0], 1'b1);
      end else if (held_n >= 2'd2) begin
        emit(held[15:8], 1'b1);
        emit(held[7:0], 1'b1);
      end
      go_plain();
    endfunction

    function void flush_hex();
      emit("x", 1'b1);
      if (held_n >= 2'd1) emit(held[7:0], 1'b1);
      go_plain();
    endfunction

    function void escaped(logic [7:0] c);
      go_plain();
      case (c)
        "a": emit(8'd7, 1'b1);
        "b": emit(8'd8, 1'b1);
        "f": emit(8'd12, 1'b1);
        "n": emit(8'd10, 1'b1);
        "r": emit(8'd13, 1'b1);
        "t": emit(8'd9, 1'b1);
        "v": emit(8'd11, 1'b1);
        "x": mode = SCAN_HEX;
        default: begin
          if (is_oct(c)) begin
            mode   = SCAN_OCT;
            held   = {8'h00, c};
            held_n = 2'd1;
          end else begin
            emit(c, 1'b1);
          end
        end
      endcase
    endfunction

    // Predict the characters caused by one transferred input character
    function void predict_char(logic [7:0] c, logic last);
      int n;
      step_chars.delete();
      step_has.delete();
      case (mode)
        SCAN_ESC: escaped(c);
        SCAN_OCT: begin
          if (is_oct(c) && (held_n < 2'd2)) begin
            held   = {held[7:0], c};
            held_n = 2'd2;
          end else if (is_oct(c)) begin
            // three digits, low 8 bits of the value
            emit({held[9:8], held[2:0], c[2:0]}, 1'b1);
            go_plain();
          end else begin
            flush_oct();
            plain_char(c);
          end
        end
        SCAN_HEX: begin
          if (is_hex(c) && (held_n == 2'd0)) begin
            held   = {8'h00, c};
            held_n = 2'd1;
          end else if (is_hex(c)) begin
            emit({hex_val(held[7:0]), hex_val(c)}, 1'b1);
            go_plain();
          end else begin
            flush_hex();
            plain_char(c);
          end
        end
        default: begin
          mode = SCAN_PLAIN;
          plain_char(c);
        end
      endcase
      // end of string flushes pending runs and always yields something
      if (last) begin
        if (mode == SCAN_OCT) flush_oct();
        else if (mode == SCAN_HEX) flush_hex();
        go_plain();
        if (step_chars.size() == 0) emit(8'h00, 1'b0);
      end
      n = step_chars.size();
      for (int k = 0; k < n; k++) begin
        expected_chars.push_back('{ch: step_chars[k], has_char: step_has[k],
                                   run_end: (k == n - 1), str_end: last});
      end
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= ReportLimit) $display("MISMATCH: %s", msg);
    endfunction

    // Compare one result transfer with the oldest expected character
    function void check_char(decoded_t got);
      decoded_t want;
      if (expected_chars.size() == 0) begin
        report($sformatf("unexpected result byte=%h valid=%b run_last=%b end=%b",
                         got.ch, got.has_char, got.run_end, got.str_end));
        return;
      end
      want = expected_chars.pop_front();
      if ((got.ch !== want.ch) || (got.has_char !== want.has_char) ||
          (got.run_end !== want.run_end) || (got.str_end !== want.str_end)) begin
        report($sformatf("exp byte=%h valid=%b run_last=%b end=%b, got %h %b %b %b",
                         want.ch, want.has_char, want.run_end, want.str_end,
                         got.ch, got.has_char, got.run_end, got.str_end));
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] in_byte_i;
  logic       string_last_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] out_byte_o;
  logic       byte_valid_o;
  logic       run_last_o;
  logic       string_end_o;

  unescape_checker checker_h = new();

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned chars_sent     = 0;
  int unsigned cycle_cnt      = 0;
  logic [7:0]  text_q[$];

  string esc_letters = "abfnrtv";
  string hex_digits  = "0123456789abcdefABCDEF";

  c_escape_sequence_decoder_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .string_last_i(string_last_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .run_last_o   (run_last_o),
    .string_end_o (string_end_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver backpressure, changed at the falling edge
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      checker_h.check_char('{ch: out_byte_o, has_char: byte_valid_o,
                             run_end: run_last_o, str_end: string_end_o});
    end
  end

  // Offer one character and hold it until the transfer
  task automatic send_char(logic [7:0] c, logic last);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    in_byte_i     <= c;
    string_last_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    checker_h.predict_char(c, last);
    chars_sent++;
  endtask

  task automatic send_text(string s, bit ends);
    for (int i = 0; i < s.len(); i++) send_char(s[i], ends && (i == s.len() - 1));
  endtask

  // Sender holds off until every expected character has arrived
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (checker_h.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Append one random escape token to the string under construction
  function automatic void add_token();
    int unsigned pick;
    int unsigned n;
    logic [7:0]  c;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      c = 8'($urandom_range(32, 126));
      text_q.push_back((c == "\\") ? "q" : c);
    end else if (pick < 40) begin
      text_q.push_back("\\");
      text_q.push_back(esc_letters[$urandom_range(0, 6)]);
    end else if (pick < 55) begin
      text_q.push_back("\\");
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
        c = 8'("0" + $urandom_range(0, 7));
        // favor a lone zero now and then
        if ((n == 1) && ($urandom_range(0, 1) == 0)) c = "0";
        text_q.push_back(c);
      end
    end else if (pick < 70) begin
      text_q.push_back("\\");
      text_q.push_back("x");
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1) : 2;
      for (int i = 0; i < n; i++) text_q.push_back(hex_digits[$urandom_range(0, 21)]);
    end else if (pick < 80) begin
      text_q.push_back("\\");
      text_q.push_back(8'($urandom_range(0, 255)));
    end else if (pick < 88) begin
      text_q.push_back("\\");
      text_q.push_back("\\");
    end else begin
      text_q.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  // Random strings until the phase has sent its share
  task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct);
    int unsigned start;
    int unsigned ntok;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start = chars_sent;
    while (chars_sent - start < PhaseChars) begin
      text_q.delete();
      ntok = $urandom_range(1, 6);
      for (int i = 0; i < ntok; i++) add_token();
      if ($urandom_range(0, 19) == 0) text_q.push_back("\\");
      for (int i = 0; i < text_q.size(); i++) send_char(text_q[i], i == text_q.size() - 1);
    end
    drain();
  endtask

  // Main sequence
  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_byte_i     = 8'h00;
    string_last_i = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: hex, lone zero, long and short octal runs, bad hex digit,
    // escaped NUL, top byte, trailing backslash, bare \x at the end
    send_text("\\x41\\0z", 1'b0);
    send_text("\\1234", 1'b0);
    send_text("\\12z", 1'b0);
    send_text("\\xAg", 1'b0);
    send_char("\\", 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char("\\", 1'b1);
    send_text("\\x", 1'b1);
    send_text("\\0", 1'b1);
    drain();

    run_phase(0, 0);
    run_phase(49, 0);
    run_phase(0, 49);
    run_phase(6, 6);

    repeat (8) @(posedge clk_i);
    if (checker_h.mismatches == 0 && checker_h.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
